@@ rtl/core/tspt_pkg.sv @@
// ----------------------------------------------------------------------------
// tspt_pkg: shared types and constants of the segment placement tracker
// Flow table geometry, status codes, sequencer states and flag bits.
// ----------------------------------------------------------------------------
`default_nettype none
package tspt_pkg;
  localparam int FLOW_SLOTS   = 64;
  localparam int BUFFER_BYTES = 256 * 1024;
  localparam int SLOT_W       = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
  localparam int HALF_W       = SLOT_W + 1;
  localparam int OFF_W        = 19;

  localparam logic [7:0] FLAG_SYN = 8'h02;
  localparam logic [7:0] FLAG_FIN = 8'h01;

  typedef enum logic [2:0] {
    ST_WRITTEN   = 3'd0,
    ST_IGNORED   = 3'd1,
    ST_FULL      = 3'd2,
    ST_COMPLETE  = 3'd3,
    ST_NO_SYN    = 3'd4,
    ST_DUPLICATE = 3'd5,
    ST_BEYOND    = 3'd6,
    ST_FLUSHED   = 3'd7
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FLUSH,
    S_SCAN_REQ,
    S_SCAN_CHK,
    S_ALLOC,
    S_HALF_REQ,
    S_HALF_RD,
    S_EVAL,
    S_DONE
  } state_t;
endpackage
`default_nettype wire

@@ rtl/core/tspt_flow_table.sv @@
// ----------------------------------------------------------------------------
// tspt_flow_table: flow key memory
// Holds address and port keys of every slot, one registered read port and
// one write port. Entries are valid only once written on allocation.
// ----------------------------------------------------------------------------
`default_nettype none
module tspt_flow_table (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [tspt_pkg::SLOT_W-1:0] wr_addr,
  input  wire logic [95:0]                wr_data,
  input  wire logic [tspt_pkg::SLOT_W-1:0] rd_addr,
  output logic      [95:0]                rd_data
);
  import tspt_pkg::*;

  logic [95:0] mem [FLOW_SLOTS];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

@@ rtl/core/tcp_segment_placement_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// tcp_segment_placement_tracker_unit: TCP segment placement tracker
// Matches segment headers to flows and tells a DMA where payload bytes go.
// ----------------------------------------------------------------------------
// Usage: drive the in_ ports and pulse start while busy is low; the
// transaction is taken on that edge and busy rises. One result per item is
// shown for one cycle with out_valid high; the receiver cannot stall it.
// Sequence: the sequencer walks the flow table slot by slot (memory read,
// then compare) until a match, allocates a free slot when none matches,
// then reads the half state and evaluates; a full table answers once the
// last slot is checked. A flush sweeps the done bits one slot a cycle.
// Ignored items go straight to the result. busy is low again in the result
// cycle, so the next item can be taken on the edge that ends it. One item
// is in flight at a time.
// Reset: slot valid, done, started and FIN bits clear at once; key and
// sequence memories need no clearing since they are read only after being
// written, and a half's fill length reads as zero until the half has started.
// No clearing pass is run.
// ----------------------------------------------------------------------------
`default_nettype none
module tcp_segment_placement_tracker_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_operation,
  input  wire logic        in_is_tcp,
  input  wire logic [31:0] in_src_ip,
  input  wire logic [31:0] in_dst_ip,
  input  wire logic [15:0] in_src_port,
  input  wire logic [15:0] in_dst_port,
  input  wire logic [31:0] in_seq_num,
  input  wire logic [15:0] in_payload_len,
  input  wire logic [7:0]  in_tcp_flags,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [5:0]       out_slot,
  output logic             out_direction,
  output logic             out_new_flow,
  output logic [18:0]      out_write_offset,
  output logic [15:0]      out_payload_skip,
  output logic [15:0]      out_write_len,
  output logic [18:0]      out_fill_length,
  output logic             out_flow_complete
);
  import tspt_pkg::*;

  localparam int CNT_W = SLOT_W + 1;

  state_t state_r, state_nxt;

  // captured transaction
  logic [31:0] sip_r, dip_r, seq_r;
  logic [15:0] sp_r, dp_r, len_r;
  logic [7:0]  flg_r;

  // control bits in flip-flops
  logic [FLOW_SLOTS-1:0]   valid_r, done_r;
  logic [2*FLOW_SLOTS-1:0] started_r, fin_r;

  // scan
  logic [CNT_W-1:0]  idx_r;
  logic [SLOT_W-1:0] slot_r, empty_r;
  logic              empty_ok_r, isnew_r, dir_r;

  // per-half memories
  logic [31:0]    base_mem [2*FLOW_SLOTS];
  logic [OFF_W-1:0] next_mem [2*FLOW_SLOTS];
  logic [OFF_W-1:0] fill_mem [2*FLOW_SLOTS];
  logic [31:0]    base_rd;
  logic [OFF_W-1:0] next_rd, fill_rd, fill_eff;
  logic           half_we;
  logic [31:0]    base_wd;
  logic [OFF_W-1:0] next_wd, fill_wd;
  logic           base_we;

  // key memory
  logic        kt_we;
  logic [95:0] kt_rd;
  logic [SLOT_W-1:0] kt_raddr;

  logic [HALF_W-1:0] h_idx;
  assign h_idx = {slot_r, dir_r};

  assign kt_raddr = idx_r[SLOT_W-1:0];

  tspt_flow_table u_table (
    .clk    (clk),
    .wr_en  (kt_we),
    .wr_addr(empty_r),
    .wr_data({sip_r, dip_r, sp_r, dp_r}),
    .rd_addr(kt_raddr),
    .rd_data(kt_rd)
  );

  // half state memories, registered read
  always_ff @(posedge clk) begin
    if (half_we) begin
      next_mem[h_idx] <= next_wd;
      fill_mem[h_idx] <= fill_wd;
    end
    if (base_we) begin
      base_mem[h_idx] <= base_wd;
    end
    base_rd <= base_mem[h_idx];
    next_rd <= next_mem[h_idx];
    fill_rd <= fill_mem[h_idx];
  end

  // fill length is zero until the half has started
  assign fill_eff = started_r[h_idx] ? fill_rd : '0;

  // key compare on the registered read word
  logic match_fwd, match_rev, hit, last;
  assign match_fwd = (kt_rd == {sip_r, dip_r, sp_r, dp_r});
  assign match_rev = (kt_rd == {dip_r, sip_r, dp_r, sp_r});
  assign hit  = valid_r[kt_raddr] && (match_fwd || match_rev);
  assign last = (idx_r == CNT_W'(FLOW_SLOTS - 1));

  // evaluation of the segment against the half (combinational add/compare logic)
  logic        syn, fin, first_syn, started_now, half_fin_other;
  logic [31:0] rel32;
  logic [32:0] end_w;
  logic        retrans, trim, beyond;
  logic [32:0] rel_eff;
  logic [15:0] skip;
  logic [OFF_W-1:0] next_cur, fill_new;
  assign syn = |(flg_r & FLAG_SYN);
  assign fin = |(flg_r & FLAG_FIN);
  assign first_syn = !started_r[h_idx] && syn;
  assign started_now = started_r[h_idx] || syn;
  assign half_fin_other = fin_r[{slot_r, !dir_r}];
  // first SYN: payload starts right after the SYN byte
  assign rel32 = first_syn ? 32'd1 : seq_r - base_rd;
  assign next_cur = first_syn ? OFF_W'(1) : next_rd;
  assign end_w = {1'b0, rel32} + 33'(len_r);
  assign retrans = (len_r == 16'd0) || (end_w <= 33'(next_cur));
  assign trim = {1'b0, rel32} < 33'(next_cur);
  assign rel_eff = trim ? 33'(next_cur) : {1'b0, rel32};
  assign skip = trim ? 16'(33'(next_cur) - {1'b0, rel32}) : 16'd0;
  assign beyond = end_w > 33'(BUFFER_BYTES);
  assign fill_new = (end_w[OFF_W-1:0] > fill_eff) ? end_w[OFF_W-1:0] : fill_eff;

  // result fields of the evaluated segment
  status_t          ev_status;
  logic             fin_set, ev_complete;
  logic [OFF_W-1:0] ev_woff, ev_fill;
  logic [15:0]      ev_skip, ev_wlen;
  always_comb begin
    fin_set     = 1'b0;
    ev_status   = ST_WRITTEN;
    ev_woff     = '0;
    ev_skip     = '0;
    ev_wlen     = '0;
    ev_fill     = fill_eff;
    ev_complete = 1'b0;
    if (done_r[slot_r]) begin
      ev_status   = ST_COMPLETE;
      ev_complete = 1'b1;
    end else if (!started_now) begin
      ev_status = ST_NO_SYN;
    end else begin
      if (first_syn && len_r == 16'd0) begin
        ev_status = ST_DUPLICATE;
        fin_set   = fin;
      end else if (retrans) begin
        ev_status = ST_DUPLICATE;
        fin_set   = (len_r == 16'd0) && fin;
      end else if (beyond) begin
        ev_status = ST_BEYOND;
        ev_woff   = rel_eff[OFF_W-1:0];
        ev_skip   = skip;
      end else begin
        fin_set = fin;
        ev_woff = rel_eff[OFF_W-1:0];
        ev_skip = skip;
        ev_wlen = len_r - skip;
        ev_fill = fill_new;
      end
      // rejected segments leave the FIN state alone
      if (ev_status != ST_BEYOND) begin
        ev_complete = (fin_set || fin_r[h_idx]) && half_fin_other;
      end
    end
  end

  // next-state logic
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_operation) begin
            state_nxt = S_FLUSH;
          end else if (!in_is_tcp ||
                       (in_payload_len == 16'd0 && (in_tcp_flags & (FLAG_SYN | FLAG_FIN)) == 8'd0)) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN_REQ;
          end
        end
      end
      S_FLUSH:    state_nxt = last ? S_DONE : S_FLUSH;
      S_SCAN_REQ: state_nxt = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (hit) begin
          state_nxt = S_HALF_REQ;
        end else if (last) begin
          state_nxt = (empty_ok_r || !valid_r[kt_raddr]) ? S_ALLOC : S_DONE;
        end else begin
          state_nxt = S_SCAN_REQ;
        end
      end
      S_ALLOC:    state_nxt = S_HALF_REQ;
      S_HALF_REQ: state_nxt = S_HALF_RD;
      S_HALF_RD:  state_nxt = S_EVAL;
      S_EVAL:     state_nxt = S_IDLE;
      S_DONE:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // output-side control decodes
  always_comb begin
    busy    = (state_r != S_IDLE);
    kt_we   = (state_r == S_ALLOC);
    half_we = 1'b0;
    base_we = 1'b0;
    base_wd = seq_r;
    next_wd = end_w[OFF_W-1:0];
    fill_wd = fill_new;
    if (state_r == S_EVAL && !done_r[slot_r] && started_now) begin
      if (first_syn) begin
        base_we = 1'b1;
        half_we = 1'b1;
        next_wd = OFF_W'(1);
        fill_wd = fill_eff;
      end
      if (!retrans && !beyond) begin
        half_we = 1'b1;
        next_wd = end_w[OFF_W-1:0];
        fill_wd = fill_new;
      end
    end
  end

  // sequencer registers and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      valid_r    <= '0;
      done_r     <= '0;
      started_r  <= '0;
      fin_r      <= '0;
      out_valid  <= 1'b0;
      idx_r      <= '0;
      empty_ok_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= (state_r == S_EVAL) || (state_r == S_DONE);
      case (state_r)
        S_IDLE: begin
          if (start) begin
            sip_r <= in_src_ip;   dip_r <= in_dst_ip;
            sp_r  <= in_src_port; dp_r  <= in_dst_port;
            seq_r <= in_seq_num;  len_r <= in_payload_len;
            flg_r <= in_tcp_flags;
            idx_r <= '0;
            empty_ok_r <= 1'b0;
            isnew_r <= 1'b0;
            out_status <= in_operation ? ST_FLUSHED : ST_IGNORED;
            out_slot <= '0; out_direction <= 1'b0; out_new_flow <= 1'b0;
            out_write_offset <= '0; out_payload_skip <= '0; out_write_len <= '0;
            out_fill_length <= '0; out_flow_complete <= 1'b0;
          end
        end
        S_FLUSH: begin
          if (valid_r[kt_raddr]) done_r[kt_raddr] <= 1'b1;
          idx_r <= idx_r + CNT_W'(1);
        end
        S_SCAN_CHK: begin
          if (!valid_r[kt_raddr] && !empty_ok_r) begin
            empty_ok_r <= 1'b1;
            empty_r    <= kt_raddr;
          end
          if (hit) begin
            slot_r <= kt_raddr;
            dir_r  <= !(kt_rd[95:64] == sip_r && kt_rd[31:16] == sp_r);
          end else if (last && !(empty_ok_r || !valid_r[kt_raddr])) begin
            out_status <= ST_FULL;
          end
          idx_r <= idx_r + CNT_W'(1);
        end
        S_ALLOC: begin
          valid_r[empty_r] <= 1'b1;
          done_r[empty_r]  <= 1'b0;
          started_r[{empty_r, 1'b0} +: 2] <= 2'b00;
          fin_r[{empty_r, 1'b0} +: 2]     <= 2'b00;
          slot_r  <= empty_r;
          dir_r   <= 1'b0;
          isnew_r <= 1'b1;
        end
        S_EVAL: begin
          out_status        <= ev_status;
          out_slot          <= 6'(slot_r);
          out_direction     <= dir_r;
          out_new_flow      <= isnew_r;
          out_write_offset  <= ev_woff;
          out_payload_skip  <= ev_skip;
          out_write_len     <= ev_wlen;
          out_fill_length   <= ev_fill;
          out_flow_complete <= ev_complete;
          if (first_syn && !done_r[slot_r]) started_r[h_idx] <= 1'b1;
          if (fin_set) fin_r[h_idx] <= 1'b1;
          if (ev_complete) done_r[slot_r] <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/tspt_checker.sv @@
// ----------------------------------------------------------------------------
// tspt_checker: port-level checks of the placement tracker
// Watches the command and result ports over time.
// ----------------------------------------------------------------------------
`default_nettype none
module tspt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [2:0]  out_status,
  input wire logic [15:0] out_write_len,
  input wire logic        out_flow_complete
);
  import tspt_pkg::*;

  // an accepted transaction makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("not busy after accept");
  // a result ends the transaction
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("busy with result");
  // only written segments carry a copy length
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_WRITTEN |-> out_write_len == 16'd0)
    else $error("copy length on non-written result");
  // status complete always reports complete flow
  a_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_COMPLETE |-> out_flow_complete)
    else $error("complete status without flag");
endmodule

bind tcp_segment_placement_tracker_unit tspt_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_status(out_status), .out_write_len(out_write_len),
  .out_flow_complete(out_flow_complete)
);
`default_nettype wire

@@ verif/tb_tcp_segment_placement_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// tb_tcp_segment_placement_tracker_unit: self-checking bench of the tracker
// Drives segment headers and flush commands from a queue, predicts each
// placement result with a behavioral flow table, and checks every strobed
// result in order against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_tcp_segment_placement_tracker_unit;
  import tspt_pkg::*;

  localparam int NPOOL = 256;

  typedef struct {
    logic        op;
    logic        tcp;
    logic [31:0] sip;
    logic [31:0] dip;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [31:0] seq;
    logic [15:0] len;
    logic [7:0]  flags;
    bit          drain;   // hold until all results are back
  } seg_t;

  typedef struct {
    status_t     status;
    logic [5:0]  slot;
    logic        dir;
    logic        new_flow;
    logic [18:0] woff;
    logic [15:0] skip;
    logic [15:0] wlen;
    logic [18:0] fill;
    logic        complete;
  } place_t;

  logic clk, rst_n, start, busy;
  logic in_operation, in_is_tcp;
  logic [31:0] in_src_ip, in_dst_ip, in_seq_num;
  logic [15:0] in_src_port, in_dst_port, in_payload_len;
  logic [7:0]  in_tcp_flags;
  logic        out_valid, out_direction, out_new_flow, out_flow_complete;
  logic [2:0]  out_status;
  logic [5:0]  out_slot;
  logic [18:0] out_write_offset, out_fill_length;
  logic [15:0] out_payload_skip, out_write_len;

  tcp_segment_placement_tracker_unit u_top (
    .clk, .rst_n, .start, .busy,
    .in_operation, .in_is_tcp, .in_src_ip, .in_dst_ip, .in_src_port, .in_dst_port,
    .in_seq_num, .in_payload_len, .in_tcp_flags,
    .out_valid, .out_status, .out_slot, .out_direction, .out_new_flow,
    .out_write_offset, .out_payload_skip, .out_write_len, .out_fill_length,
    .out_flow_complete
  );

  seg_t   pending_segs[$];
  place_t expected_placements[$];
  int     fails = 0;
  int     accepted = 0;

  // predicted flow table
  bit              f_valid[FLOW_SLOTS];
  bit              f_done[FLOW_SLOTS];
  logic [63:0]     f_addr[FLOW_SLOTS];
  logic [31:0]     f_ports[FLOW_SLOTS];
  bit              h_started[2*FLOW_SLOTS];
  logic [31:0]     h_base[2*FLOW_SLOTS];
  longint unsigned h_next[2*FLOW_SLOTS];
  longint unsigned h_fill[2*FLOW_SLOTS];
  bit              h_fin[2*FLOW_SLOTS];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Work out the placement of one accepted transaction.
  task automatic predict_placement(input seg_t s);
    place_t r;
    int slot, empty, h;
    logic [63:0] fa, ra;
    logic [31:0] fp, rp, seq, rel32;
    longint unsigned rel, fin_end, nx, skip;
    r = '{status: ST_IGNORED, default: '0};
    slot = -1; empty = -1; skip = 0;
    seq = s.seq;
    if (s.op) begin
      for (int i = 0; i < FLOW_SLOTS; i++) if (f_valid[i]) f_done[i] = 1;
      r.status = ST_FLUSHED;
      expected_placements.push_back(r);
      return;
    end
    if (!s.tcp || (s.len == 0 && (s.flags & (FLAG_SYN | FLAG_FIN)) == 0)) begin
      expected_placements.push_back(r);
      return;
    end
    fa = {s.sip, s.dip}; ra = {s.dip, s.sip};
    fp = {s.sp, s.dp};   rp = {s.dp, s.sp};
    for (int i = 0; i < FLOW_SLOTS; i++) begin
      if (!f_valid[i]) begin
        if (empty < 0) empty = i;
      end else if ((f_addr[i] == fa && f_ports[i] == fp) ||
                   (f_addr[i] == ra && f_ports[i] == rp)) begin
        slot = i;
        break;
      end
    end
    if (slot < 0) begin
      if (empty < 0) begin
        r.status = ST_FULL;
        expected_placements.push_back(r);
        return;
      end
      slot = empty;
      r.new_flow = 1'b1;
      f_valid[slot] = 1; f_done[slot] = 0;
      f_addr[slot] = fa; f_ports[slot] = fp;
      for (int i = 0; i < 2; i++) begin
        h_started[2*slot+i] = 0; h_fill[2*slot+i] = 0; h_fin[2*slot+i] = 0;
      end
    end
    r.slot = 6'(slot);
    r.dir = !(f_addr[slot][63:32] == s.sip && f_ports[slot][31:16] == s.sp);
    h = 2*slot + r.dir;
    r.fill = 19'(h_fill[h]);
    if (f_done[slot]) begin
      r.status = ST_COMPLETE;
      r.complete = 1'b1;
      expected_placements.push_back(r);
      return;
    end
    // first SYN of this half sets the base
    if (!h_started[h] && (s.flags & FLAG_SYN)) begin
      h_base[h] = seq; h_next[h] = 1; h_started[h] = 1;
      if (s.len == 0) begin
        if (s.flags & FLAG_FIN) h_fin[h] = 1;
        if (h_fin[2*slot] && h_fin[2*slot+1]) f_done[slot] = 1;
        r.status = ST_DUPLICATE;
        r.complete = f_done[slot];
        expected_placements.push_back(r);
        return;
      end
      seq = seq + 32'd1;
    end
    if (!h_started[h]) begin
      r.status = ST_NO_SYN;
      expected_placements.push_back(r);
      return;
    end
    rel32 = seq - h_base[h];
    rel = rel32;
    fin_end = rel + s.len;
    nx = h_next[h];
    // retransmission or bare control segment
    if (s.len == 0 || fin_end <= nx) begin
      if (s.len == 0 && (s.flags & FLAG_FIN)) h_fin[h] = 1;
      if (h_fin[2*slot] && h_fin[2*slot+1]) f_done[slot] = 1;
      r.status = ST_DUPLICATE;
      r.complete = f_done[slot];
      expected_placements.push_back(r);
      return;
    end
    if (rel < nx) begin
      skip = nx - rel;
      rel = nx;
    end
    r.woff = rel[18:0];
    r.skip = skip[15:0];
    if (fin_end > BUFFER_BYTES) begin
      r.status = ST_BEYOND;
      expected_placements.push_back(r);
      return;
    end
    if (fin_end > h_fill[h]) h_fill[h] = fin_end;
    h_next[h] = fin_end;
    if (s.flags & FLAG_FIN) h_fin[h] = 1;
    if (h_fin[2*slot] && h_fin[2*slot+1]) f_done[slot] = 1;
    r.status = ST_WRITTEN;
    r.wlen = s.len - skip[15:0];
    r.fill = 19'(h_fill[h]);
    r.complete = f_done[slot];
    expected_placements.push_back(r);
  endtask

  // Driver: one transaction on the ports at a time.
  seg_t cur;
  int   idle_pct;
  logic nstart;
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      nstart = start;
      if (start && !busy) begin
        predict_placement(cur);
        accepted++;
        nstart = 1'b0;
      end
      idle_pct = (accepted < 300) ? 15 : (accepted < 600) ? 82 : 0;
      if (!nstart && pending_segs.size() > 0 && $urandom_range(0, 99) >= idle_pct &&
          !(pending_segs[0].drain && expected_placements.size() > 0)) begin
        cur = pending_segs.pop_front();
        in_operation   <= cur.op;
        in_is_tcp      <= cur.tcp;
        in_src_ip      <= cur.sip;
        in_dst_ip      <= cur.dip;
        in_src_port    <= cur.sp;
        in_dst_port    <= cur.dp;
        in_seq_num     <= cur.seq;
        in_payload_len <= cur.len;
        in_tcp_flags   <= cur.flags;
        nstart = 1'b1;
      end
      start <= nstart;
    end
  end

  task automatic chk(input string name, input longint unsigned e, input longint unsigned a);
    if (e != a) begin
      $display("%0t %s expected %0d actual %0d", $time, name, e, a);
      fails++;
    end
  endtask

  // Monitor: results cannot be stalled, take them on the strobe.
  always @(posedge clk) begin
    place_t e;
    if (rst_n && out_valid) begin
      if (expected_placements.size() == 0) begin
        $display("%0t unexpected result status %0d", $time, out_status);
        fails++;
      end else begin
        e = expected_placements.pop_front();
        chk("status", e.status, out_status);
        chk("slot", e.slot, out_slot);
        chk("direction", e.dir, out_direction);
        chk("new_flow", e.new_flow, out_new_flow);
        chk("write_offset", e.woff, out_write_offset);
        chk("payload_skip", e.skip, out_payload_skip);
        chk("write_len", e.wlen, out_write_len);
        chk("fill_length", e.fill, out_fill_length);
        chk("flow_complete", e.complete, out_flow_complete);
      end
    end
  end

  // stimulus generator state
  logic [31:0] t_sip[NPOOL], t_dip[NPOOL], t_base[NPOOL][2], t_next[NPOOL][2];
  logic [15:0] t_sp[NPOOL], t_dp[NPOOL];
  bit          t_syn[NPOOL][2], t_fin[NPOOL][2];
  int          t_cnt[NPOOL], t_life[NPOOL];
  int          active[4];
  int          next_pool;

  task automatic push_seg(input int f, input bit d, input logic [31:0] seq,
                          input logic [15:0] len, input logic [7:0] flags,
                          input bit drain = 0);
    seg_t s;
    s = '{op: 0, tcp: 1, sip: d ? t_dip[f] : t_sip[f], dip: d ? t_sip[f] : t_dip[f],
          sp: d ? t_dp[f] : t_sp[f], dp: d ? t_sp[f] : t_dp[f],
          seq: seq, len: len, flags: flags, drain: drain};
    pending_segs.push_back(s);
  endtask

  task automatic push_ctl(input bit op, input bit tcp, input logic [15:0] len,
                          input logic [7:0] flags, input bit drain = 0);
    seg_t s;
    s = '{op: op, tcp: tcp, sip: $urandom, dip: $urandom, sp: 16'($urandom),
          dp: 16'($urandom), seq: $urandom, len: len, flags: flags, drain: drain};
    pending_segs.push_back(s);
  endtask

  function automatic logic [15:0] rand_len();
    case ($urandom_range(0, 19))
      0:       return 16'($urandom_range(0, 65535));
      1:       return 16'hFFFF;
      2, 3:    return 16'd0;
      default: return 16'($urandom_range(1, 300));
    endcase
  endfunction

  function automatic logic [7:0] rand_flags(input bit syn, input bit fin);
    logic [7:0] f;
    f = 8'($urandom);
    f = f & ~(FLAG_SYN | FLAG_FIN);
    if (syn) f = f | FLAG_SYN;
    if (fin) f = f | FLAG_FIN;
    return f;
  endfunction

  // One segment of random content on an active flow.
  task automatic gen_flow_seg();
    int k, f;
    bit d;
    logic [15:0] len;
    logic [31:0] seq;
    bit fin;
    k = $urandom_range(0, 3);
    f = active[k];
    d = 1'($urandom_range(0, 1));
    len = rand_len();
    t_cnt[f]++;
    if (!t_syn[f][d]) begin
      if ($urandom_range(0, 99) < 85) begin
        seq = $urandom;
        t_base[f][d] = seq;
        t_next[f][d] = seq + 1 + len;
        t_syn[f][d] = 1;
        fin = ($urandom_range(0, 19) == 0);
        if (fin) t_fin[f][d] = 1;
        push_seg(f, d, seq, len, rand_flags(1, fin));
      end else begin
        push_seg(f, d, $urandom, len, rand_flags(0, 1'($urandom_range(0, 1))));
      end
    end else begin
      fin = (t_cnt[f] > t_life[f]) && ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 9))
        0:       seq = t_next[f][d] - len - $urandom_range(0, 50);   // retransmit
        1, 2:    seq = t_next[f][d] - $urandom_range(1, 40);         // front overlap
        3:       seq = t_next[f][d] + $urandom_range(1, 500);        // gap
        4:       seq = $urandom;                                     // wild
        5:       seq = t_base[f][d] - $urandom_range(0, 20);         // before base
        default: seq = t_next[f][d];
      endcase
      if (fin && $urandom_range(0, 1)) len = 0;
      if (fin) t_fin[f][d] = 1;
      if (seq + len - t_next[f][d] < 32'h8000_0000) t_next[f][d] = seq + len;
      push_seg(f, d, seq, len, rand_flags($urandom_range(0, 9) == 0, fin));
    end
    if (t_fin[f][0] && t_fin[f][1] || t_cnt[f] > t_life[f] + 30) begin
      active[k] = next_pool;
      if (next_pool < NPOOL - 1) next_pool++;
    end
  endtask

  initial begin
    logic [31:0] b;
    rst_n = 0; start = 0;
    in_operation = 0; in_is_tcp = 0; in_src_ip = 0; in_dst_ip = 0;
    in_src_port = 0; in_dst_port = 0; in_seq_num = 0; in_payload_len = 0;
    in_tcp_flags = 0;
    for (int i = 0; i < NPOOL; i++) begin
      t_sip[i] = $urandom; t_dip[i] = $urandom;
      t_sp[i] = 16'($urandom); t_dp[i] = 16'($urandom);
      t_syn[i] = '{0, 0}; t_fin[i] = '{0, 0};
      t_cnt[i] = 0; t_life[i] = $urandom_range(4, 25);
    end
    // extreme tuples for the directed part
    t_sip[0] = '1; t_dip[0] = '0; t_sp[0] = '1; t_dp[0] = '0;
    t_sip[1] = '0; t_dip[1] = '1; t_sp[1] = '0; t_dp[1] = '1;

    // directed: ignored items
    push_ctl(0, 0, 16'hFFFF, 8'hFF);
    push_ctl(0, 1, 0, 8'hFC);
    // half not started, no SYN
    push_seg(2, 0, 32'h1000, 10, 8'h00);
    // SYN only, then placement cases on flow 0
    b = 32'hFFFF_FFF0;
    push_seg(0, 0, b, 0, FLAG_SYN);
    push_seg(0, 0, b + 1, 100, 8'h00);          // in order
    push_seg(0, 0, b + 1, 50, 8'h00);           // retransmit
    push_seg(0, 0, b + 81, 40, 8'hF0);          // front overlap
    push_seg(0, 0, b + 300, 16'hFFFF, 8'h00);   // gap
    push_seg(0, 0, b - 5, 20, 8'h00);           // before base
    push_seg(0, 0, b + 262100, 100, 8'h00);     // beyond buffer
    push_seg(0, 0, b, 0, FLAG_FIN);             // zero-length FIN
    // reverse SYN with payload and FIN completes the flow
    push_seg(0, 1, 32'h0, 16'hFFFF, FLAG_SYN | FLAG_FIN);
    push_seg(0, 0, b + 500, 10, 8'h00);         // flow done
    // SYN+FIN without payload in both halves
    push_seg(1, 0, 32'h8000_0000, 0, FLAG_SYN | FLAG_FIN);
    push_seg(1, 1, 32'h7FFF_FFFF, 0, 8'hFF);
    // flush with open flow 2, then a segment to it
    push_seg(2, 1, 32'h0, 5, FLAG_SYN);
    push_ctl(1, 0, 0, 0);
    push_seg(2, 1, 32'h6, 5, 8'h00);
    push_ctl(1, 1, 16'hFFFF, 8'hFF);

    // random part: well-formed flows with random content
    for (int i = 0; i < 4; i++) active[i] = 3 + i;
    next_pool = 7;
    for (int n = 0; n < 880; n++) begin
      if (n == 0 || n == 450) begin
        push_ctl(0, 0, 0, 0, 1);                // pause until drained
      end else if ($urandom_range(0, 199) == 0) begin
        push_ctl(1, 1'($urandom_range(0, 1)), 16'($urandom), 8'($urandom));
      end else if ($urandom_range(0, 99) < 4) begin
        push_ctl(0, 1'($urandom_range(0, 1)), 0, rand_flags(0, 0));
      end else begin
        gen_flow_seg();
      end
    end
    // exhaust the table
    for (int i = 0; i < 70; i++) begin
      t_sip[0] = $urandom; t_dip[0] = $urandom;
      push_seg(0, 0, $urandom, 0, FLAG_SYN);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_segs.size() > 0 || start || expected_placements.size() > 0);
    repeat (300) @(posedge clk);
    if (fails == 0) begin
      $display("tcp_segment_placement_tracker_unit: match");
    end else begin
      $display("tcp_segment_placement_tracker_unit: mismatch");
    end
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("tcp_segment_placement_tracker_unit: mismatch");
    $finish;
  end
endmodule

@@ sim.f @@
rtl/core/tspt_pkg.sv
rtl/core/tspt_flow_table.sv
rtl/core/tcp_segment_placement_tracker_unit.sv
rtl/core/tspt_checker.sv
verif/tb_tcp_segment_placement_tracker_unit.sv
